// ----- rtl/core/nmi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nmi_pkg;

    localparam int ELEM_W    = 32;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int COF_W     = PROD_W + 1;
    localparam int DET_W     = 99;
    localparam int QB        = 34;                // quotient bits incl. round bit
    localparam int FRONT_LAT = 5;
    localparam int LANE_LAT  = QB + 3;
    localparam int TOTAL_LAT = FRONT_LAT + LANE_LAT + 1;

    typedef struct packed {
        logic signed [ELEM_W-1:0] in_r0_c0;
        logic signed [ELEM_W-1:0] in_r0_c1;
        logic signed [ELEM_W-1:0] in_r0_c2;
        logic signed [ELEM_W-1:0] in_r1_c0;
        logic signed [ELEM_W-1:0] in_r1_c1;
        logic signed [ELEM_W-1:0] in_r1_c2;
        logic signed [ELEM_W-1:0] in_r2_c0;
        logic signed [ELEM_W-1:0] in_r2_c1;
        logic signed [ELEM_W-1:0] in_r2_c2;
    } in_word_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] inv_r0_c0;
        logic signed [ELEM_W-1:0] inv_r0_c1;
        logic signed [ELEM_W-1:0] inv_r0_c2;
        logic signed [ELEM_W-1:0] inv_r1_c0;
        logic signed [ELEM_W-1:0] inv_r1_c1;
        logic signed [ELEM_W-1:0] inv_r1_c2;
        logic signed [ELEM_W-1:0] inv_r2_c0;
        logic signed [ELEM_W-1:0] inv_r2_c1;
        logic signed [ELEM_W-1:0] inv_r2_c2;
        logic                     singular;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/normal_matrix_inverse_3x3.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Normal-matrix unit: takes the 3x3 part of a transform (Q16.16 by default) and
// returns its inverse, row-major, rounded to nearest and saturated, with a singular
// flag (all words zero) when the exact determinant is zero. Fully pipelined: busy
// is always low, a word may be started every cycle, and each result appears on
// result with done high for one cycle. The pipeline includes the five-stage
// cofactor/determinant front end, the 34 one-bit stages of the restoring
// divider in each of the nine lanes, and the output register.
// The receiver cannot stall: capture result whenever done is high.
module normal_matrix_inverse_3x3
    import nmi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire in_word_t in_word,
    output logic          done,
    output result_t       result
);

    logic signed [COF_W-1:0]  cof [0:2][0:2];
    logic signed [DET_W-1:0]  det;
    logic signed [ELEM_W-1:0] lane_word [0:8];
    logic                     lane_zero [0:8];

    logic [TOTAL_LAT-1:0] vld_reg;
    logic [TOTAL_LAT-1:0] vld_next;
    result_t              result_reg;
    result_t              result_next;

    nmi_front u_front
    (
        .clk     (clk),
        .in_word (in_word),
        .cof     (cof),
        .det     (det)
    );

    // lane 3r+c computes inverse (r,c) = cof(c,r) / det
    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 3; c++)
        begin : g_col
            nmi_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane
            (
                .clk  (clk),
                .cof  (cof[c][r]),
                .det  (det),
                .word (lane_word[3 * r + c]),
                .zero (lane_zero[3 * r + c])
            );
        end
    end

    // merge stage: lanes into one result word
    always_comb
    begin
        result_next.inv_r0_c0 = lane_word[0];
        result_next.inv_r0_c1 = lane_word[1];
        result_next.inv_r0_c2 = lane_word[2];
        result_next.inv_r1_c0 = lane_word[3];
        result_next.inv_r1_c1 = lane_word[4];
        result_next.inv_r1_c2 = lane_word[5];
        result_next.inv_r2_c0 = lane_word[6];
        result_next.inv_r2_c1 = lane_word[7];
        result_next.inv_r2_c2 = lane_word[8];
        result_next.singular  = lane_zero[0];
    end

    assign vld_next = {vld_reg[TOTAL_LAT-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign busy   = 1'b0;
    assign done   = vld_reg[TOTAL_LAT-1];
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- rtl/core/nmi_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Cofactors and determinant, five register stages.
module nmi_front
    import nmi_pkg::*;
(
    input  wire logic                    clk,
    input  wire in_word_t                in_word,
    output logic signed [COF_W-1:0]      cof [0:2][0:2],
    output logic signed [DET_W-1:0]      det
);

    logic signed [ELEM_W-1:0] e [0:2][0:2];

    logic signed [PROD_W-1:0]   pa_reg [0:2][0:2];
    logic signed [PROD_W-1:0]   pb_reg [0:2][0:2];
    logic signed [ELEM_W-1:0]   e0_1_reg [0:2];
    logic signed [ELEM_W-1:0]   e0_2_reg [0:2];
    logic signed [COF_W-1:0]    cof2_reg [0:2][0:2];
    logic signed [COF_W-1:0]    cof3_reg [0:2][0:2];
    logic signed [COF_W-1:0]    cof4_reg [0:2][0:2];
    logic signed [COF_W-1:0]    cof5_reg [0:2][0:2];
    logic signed [2*ELEM_W:0]   plo_full_reg [0:2];
    logic signed [2*ELEM_W+1:0] phi_full_reg [0:2];
    logic signed [DET_W-1:0]    t_reg [0:2];
    logic signed [DET_W-1:0]    det_reg;

    assign e[0][0] = in_word.in_r0_c0;
    assign e[0][1] = in_word.in_r0_c1;
    assign e[0][2] = in_word.in_r0_c2;
    assign e[1][0] = in_word.in_r1_c0;
    assign e[1][1] = in_word.in_r1_c1;
    assign e[1][2] = in_word.in_r1_c2;
    assign e[2][0] = in_word.in_r2_c0;
    assign e[2][1] = in_word.in_r2_c1;
    assign e[2][2] = in_word.in_r2_c2;

    for (genvar r = 0; r < 3; r++)
    begin : g_r
        for (genvar c = 0; c < 3; c++)
        begin : g_c
            // cyclic indexing carries the cofactor sign
            always_ff @(posedge clk)
            begin
                pa_reg[r][c]   <= PROD_W'(e[(r+1)%3][(c+1)%3] * e[(r+2)%3][(c+2)%3]);
                pb_reg[r][c]   <= PROD_W'(e[(r+1)%3][(c+2)%3] * e[(r+2)%3][(c+1)%3]);
                cof2_reg[r][c] <= COF_W'(pa_reg[r][c]) - COF_W'(pb_reg[r][c]);
                cof3_reg[r][c] <= cof2_reg[r][c];
                cof4_reg[r][c] <= cof3_reg[r][c];
                cof5_reg[r][c] <= cof4_reg[r][c];
            end
            assign cof[r][c] = cof5_reg[r][c];
        end
    end

    // row-0 elements delayed to line up with the cofactors
    for (genvar c = 0; c < 3; c++)
    begin : g_det
        always_ff @(posedge clk)
        begin
            e0_1_reg[c] <= e[0][c];
            e0_2_reg[c] <= e0_1_reg[c];
        end
    end

    // row-0 expansion, cofactor split into low/high halves
    for (genvar c = 0; c < 3; c++)
    begin : g_full
        always_ff @(posedge clk)
        begin
            plo_full_reg[c] <= e0_2_reg[c] * $signed({1'b0, cof2_reg[0][c][ELEM_W-1:0]});
            phi_full_reg[c] <= e0_2_reg[c] * $signed(cof2_reg[0][c][COF_W-1:ELEM_W]);
            t_reg[c]        <= (DET_W'(phi_full_reg[c]) <<< ELEM_W) +
                               DET_W'(plo_full_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        det_reg <= t_reg[0] + t_reg[1] + t_reg[2];
    end

    assign det = det_reg;

endmodule

`default_nettype wire

// ----- rtl/core/nmi_div_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One inverse element: |cof| << 2F divided by |det|, restoring, one bit a stage.
module nmi_div_lane
    import nmi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                    clk,
    input  wire logic signed [COF_W-1:0] cof,
    input  wire logic signed [DET_W-1:0] det,
    output logic signed [ELEM_W-1:0]     word,
    output logic                         zero
);

    localparam int NW = COF_W + 2 * FRAC_BITS + 1;
    localparam int CW = (NW > DET_W + QB + 1) ? NW : DET_W + QB + 1;

    logic [COF_W-1:0] nm_reg;
    logic [DET_W-1:0] dm_reg;
    logic             neg0_reg;
    logic             zero0_reg;

    logic [CW-1:0]    rem_reg [0:QB];
    logic [CW-1:0]    d_reg   [0:QB];
    logic [QB-1:0]    q_reg   [0:QB];
    logic             neg_reg [0:QB];
    logic             zero_reg [0:QB];
    logic             ovf_reg [0:QB];

    logic signed [ELEM_W-1:0] word_reg;
    logic                     zout_reg;

    logic [COF_W-1:0] cof_neg;
    logic [DET_W-1:0] det_neg;
    logic [CW-1:0]    rem_init;
    logic [CW-1:0]    d_init;

    assign cof_neg  = -cof;
    assign det_neg  = -det;
    assign rem_init = CW'({nm_reg, {(2 * FRAC_BITS + 1){1'b0}}});
    assign d_init   = CW'(dm_reg);

    always_ff @(posedge clk)
    begin
        nm_reg    <= cof[COF_W-1] ? cof_neg : cof;
        dm_reg    <= det[DET_W-1] ? det_neg : det;
        neg0_reg  <= cof[COF_W-1] ^ det[DET_W-1];
        zero0_reg <= (det == '0);

        // overflow when 2N >= D * 2^QB
        rem_reg[0]  <= rem_init;
        d_reg[0]    <= d_init;
        q_reg[0]    <= '0;
        neg_reg[0]  <= neg0_reg;
        zero_reg[0] <= zero0_reg;
        ovf_reg[0]  <= rem_init >= (d_init << QB);
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [CW-1:0] dsh;
        logic          ge;
        assign dsh = d_reg[k-1] << (QB - k);
        assign ge  = rem_reg[k-1] >= dsh;
        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= ge ? rem_reg[k-1] - dsh : rem_reg[k-1];
            q_reg[k]    <= {q_reg[k-1][QB-2:0], ge};
            d_reg[k]    <= d_reg[k-1];
            neg_reg[k]  <= neg_reg[k-1];
            zero_reg[k] <= zero_reg[k-1];
            ovf_reg[k]  <= ovf_reg[k-1];
        end
    end

    // q holds floor(2N/D); (q+1)>>1 rounds half away from zero
    logic [QB:0]   q_inc;
    logic [QB-1:0] mag;
    logic [QB-1:0] mag_neg;
    logic signed [ELEM_W-1:0] word_next;

    assign q_inc   = {1'b0, q_reg[QB]} + (QB + 1)'(1);
    assign mag     = q_inc[QB:1];
    assign mag_neg = -mag;

    always_comb
    begin
        priority if (zero_reg[QB])
        begin
            word_next = '0;
        end
        else if (ovf_reg[QB])
        begin
            word_next = neg_reg[QB] ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
        end
        else if (!neg_reg[QB])
        begin
            word_next = (mag > QB'({1'b0, {(ELEM_W-1){1'b1}}})) ?
                        {1'b0, {(ELEM_W-1){1'b1}}} : mag[ELEM_W-1:0];
        end
        else
        begin
            word_next = (mag > QB'({1'b1, {(ELEM_W-1){1'b0}}})) ?
                        {1'b1, {(ELEM_W-1){1'b0}}} : mag_neg[ELEM_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        zout_reg <= zero_reg[QB];
    end

    assign word = word_reg;
    assign zero = zout_reg;

endmodule

`default_nettype wire
